// ===== design/dhpsg_pkg.sv =====
package dhpsg_pkg;

    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;
    localparam int THR_BITS      = 12;
    localparam int LIMIT_BITS    = 8;
    localparam int RELEASE_BITS  = 16;
    localparam int RANGE_BITS    = 7;
    localparam int SCAN_AGE_BITS = 9;
    localparam int TABLE_BITS    = 25;

    localparam logic [CFG_IDX_BITS-1:0] CFG_HIT_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SCAN_LIMIT    = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RELEASE       = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RANGE         = 2'd3;

    localparam logic [THR_BITS-1:0]     RST_HIT_THRESHOLD = 12'd100;
    localparam logic [LIMIT_BITS-1:0]   RST_SCAN_LIMIT    = 8'd20;
    localparam logic [RELEASE_BITS-1:0] RST_RELEASE       = 16'd444;
    localparam logic [RANGE_BITS-1:0]   RST_RANGE         = 7'd12;

    localparam logic [SCAN_AGE_BITS-1:0] SCAN_AGE_MAX = '1;
    localparam logic [RELEASE_BITS-1:0]  RAMP_AGE_MAX = '1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UPDATE,
        S_EVAL,
        S_DIV,
        S_OUT
    } t_state;

    // 2^(-r/6) in Q24
    function automatic logic [TABLE_BITS-1:0] frac_q24(input logic [2:0] r);
        logic [TABLE_BITS-1:0] v;
        unique case (r)
            3'd0:    v = 25'd16777216;
            3'd1:    v = 25'd14946800;
            3'd2:    v = 25'd13316085;
            3'd3:    v = 25'd11863283;
            3'd4:    v = 25'd10568984;
            3'd5:    v = 25'd9415894;
            default: v = '0;
        endcase
        return v;
    endfunction

    // floor gain 2^(-range/6) at frac_bits fraction bits, rounded half up
    function automatic logic [TABLE_BITS-1:0] floor_from_range(
        input logic [RANGE_BITS-1:0] range,
        input int unsigned           frac_bits
    );
        logic [12:0]           prod;
        logic [4:0]            q;
        logic [7:0]            q6;
        logic [2:0]            r;
        logic [5:0]            s;
        logic [TABLE_BITS-1:0] t;
        logic [TABLE_BITS:0]   sum;
        // range * 43 / 256 equals range / 6 for every 7-bit range
        prod = 13'(range) * 13'd43;
        q    = prod[12:8];
        q6   = 8'(q) * 8'd6;
        r    = 3'(8'(range) - q6);
        s    = 6'(24 - frac_bits) + 6'(q);
        t    = frac_q24(r);
        if (s == 6'd0) begin
            return t;
        end
        sum = {1'b0, t} + ((TABLE_BITS+1)'(1) << (s - 6'd1));
        return TABLE_BITS'(sum >> s);
    endfunction

endpackage

// ===== design/drum_hit_peak_scan_gate_unit.sv =====
// Drum hit scan gate. Each transaction is a piezo sample or a 1 ms tick and
// yields one result: gate gain (Q1.GAIN_FRAC_BITS), ramp flag, fire flag and
// the peak of the current or last scan. One item is in flight at a time. An
// item passes through the update, eval and output states when the gain is the
// floor, and through update, eval, division and output while the release
// ramp runs: the ramp gain comes from a radix-2 long division of
// ramp_age*(1-floor) by release_ms that consumes one bit of the span per
// cycle. The next item can be accepted in the cycle after the result is
// registered, while that result may still wait in the output register. The
// floor gain is worked out when range_db is written.
module drum_hit_peak_scan_gate_unit
    import dhpsg_pkg::*;
#(
    parameter int SAMPLE_BITS    = 12,
    parameter int GAIN_FRAC_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic                         i_cmd,
    input  logic [SAMPLE_BITS-1:0]       i_sample_value,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [GAIN_FRAC_BITS:0]      o_gate_gain,
    output logic                         o_ramp_active,
    output logic                         o_fired,
    output logic [SAMPLE_BITS-1:0]       o_peak_level,
    input  logic                         i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]      i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]     i_cfg_wdata
);

    localparam int GW        = GAIN_FRAC_BITS + 1;
    localparam int DIV_STEPS = GAIN_FRAC_BITS + 1;
    localparam int CNT_W     = $clog2(DIV_STEPS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);
    localparam logic [GW-1:0]    GAIN_ONE = {1'b1, {GAIN_FRAC_BITS{1'b0}}};
    localparam logic [GW-1:0]    RST_FLOOR_CAND =
        GW'(floor_from_range(RST_RANGE, GAIN_FRAC_BITS));

    t_state r_state, n_state;

    logic [THR_BITS-1:0]      r_hit_threshold;
    logic [LIMIT_BITS-1:0]    r_scan_limit;
    logic [RELEASE_BITS-1:0]  r_release_ms;
    logic [GW-1:0]            r_floor_cand;

    logic                     r_cmd;
    logic [SAMPLE_BITS-1:0]   r_sample;

    logic                     r_scanning;
    logic [SCAN_AGE_BITS-1:0] r_scan_age;
    logic [SAMPLE_BITS-1:0]   r_peak_hold;
    logic                     r_ramp_on;
    logic [RELEASE_BITS-1:0]  r_ramp_age;
    logic [GW-1:0]            r_floor_gain;
    logic                     r_fired;

    logic [GW-1:0]            r_span;
    logic [RELEASE_BITS-1:0]  r_rem;
    logic [GW-1:0]            r_quot;
    logic [CNT_W-1:0]         r_cnt;
    logic [GW-1:0]            r_gain;

    logic                     r_out_valid;
    logic [GW-1:0]            r_out_gain;
    logic                     r_out_ramp;
    logic                     r_out_fired;
    logic [SAMPLE_BITS-1:0]   r_out_peak;

    logic                     w_accept;
    logic                     w_out_free;
    logic                     w_load_out;
    logic                     w_ramp_run;
    logic                     w_div_last;
    logic [SAMPLE_BITS-1:0]   w_thr;
    logic                     w_qualify;
    logic [SCAN_AGE_BITS-1:0] w_age_eff;
    logic [SAMPLE_BITS-1:0]   w_peak_eff;
    logic                     w_fire;
    logic [RELEASE_BITS+1:0]  w_trial;
    logic [RELEASE_BITS+1:0]  w_rel1;
    logic [RELEASE_BITS+1:0]  w_rel2;
    logic [RELEASE_BITS-1:0]  n_rem;
    logic [1:0]               w_digit;
    logic [GW-1:0]            n_quot;

    assign w_out_free = !r_out_valid || i_ready;
    assign w_accept   = i_valid && o_ready;
    assign w_ramp_run = r_ramp_on && (r_ramp_age < r_release_ms);
    assign w_div_last = (r_cnt == CNT_LAST);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_valid) n_state = S_UPDATE;
            S_UPDATE: n_state = S_EVAL;
            S_EVAL:   n_state = w_ramp_run ? S_DIV : S_OUT;
            S_DIV:    if (w_div_last) n_state = S_OUT;
            S_OUT:    if (w_out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_ready    = 1'b0;
        w_load_out = 1'b0;
        unique case (r_state)
            S_IDLE:  o_ready    = 1'b1;
            S_OUT:   w_load_out = w_out_free;
            default: begin
                o_ready    = 1'b0;
                w_load_out = 1'b0;
            end
        endcase
    end

    // scan and fire decision for the latched sample
    always_comb begin
        w_thr      = SAMPLE_BITS'(r_hit_threshold);
        w_qualify  = !r_cmd && (r_sample >= w_thr);
        w_age_eff  = r_scanning ? r_scan_age : '0;
        w_peak_eff = r_scanning ? r_peak_hold : r_sample;
        w_fire     = w_qualify && (w_age_eff > SCAN_AGE_BITS'(r_scan_limit));
    end

    // one long-division step: remainder stays below release_ms, digit is 0..2
    always_comb begin
        w_rel1  = (RELEASE_BITS+2)'(r_release_ms);
        w_rel2  = {1'b0, r_release_ms, 1'b0};
        w_trial = {1'b0, r_rem, 1'b0}
                + (r_span[GW-1] ? (RELEASE_BITS+2)'(r_ramp_age) : '0);
        priority if (w_trial >= w_rel2) begin
            n_rem   = RELEASE_BITS'(w_trial - w_rel2);
            w_digit = 2'd2;
        end else if (w_trial >= w_rel1) begin
            n_rem   = RELEASE_BITS'(w_trial - w_rel1);
            w_digit = 2'd1;
        end else begin
            n_rem   = RELEASE_BITS'(w_trial);
            w_digit = 2'd0;
        end
        n_quot = GW'({r_quot, 1'b0} + (GW+1)'(w_digit));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_hit_threshold <= RST_HIT_THRESHOLD;
            r_scan_limit    <= RST_SCAN_LIMIT;
            r_release_ms    <= RST_RELEASE;
            r_floor_cand    <= RST_FLOOR_CAND;
            r_scanning      <= 1'b0;
            r_scan_age      <= '0;
            r_peak_hold     <= '0;
            r_ramp_on       <= 1'b0;
            r_ramp_age      <= '0;
            r_floor_gain    <= '0;
            r_fired         <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_HIT_THRESHOLD: r_hit_threshold <= i_cfg_wdata[THR_BITS-1:0];
                    CFG_SCAN_LIMIT:    r_scan_limit    <= i_cfg_wdata[LIMIT_BITS-1:0];
                    CFG_RELEASE:       r_release_ms    <= i_cfg_wdata[RELEASE_BITS-1:0];
                    CFG_RANGE:         r_floor_cand    <= GW'(floor_from_range(
                                           i_cfg_wdata[RANGE_BITS-1:0], GAIN_FRAC_BITS));
                    default: ;
                endcase
            end

            if (r_state == S_UPDATE) begin
                r_fired <= w_fire;
                if (r_cmd) begin
                    if (r_scanning && r_scan_age != SCAN_AGE_MAX) begin
                        r_scan_age <= r_scan_age + 1'b1;
                    end
                    if (r_ramp_on && r_ramp_age != RAMP_AGE_MAX) begin
                        r_ramp_age <= r_ramp_age + 1'b1;
                    end
                end else if (w_qualify) begin
                    r_scan_age <= w_age_eff;
                    if (w_fire) begin
                        // firing sample leaves the peak alone
                        r_scanning   <= 1'b0;
                        r_peak_hold  <= w_peak_eff;
                        r_ramp_on    <= 1'b1;
                        r_ramp_age   <= '0;
                        r_floor_gain <= r_floor_cand;
                    end else begin
                        r_scanning  <= 1'b1;
                        r_peak_hold <= (r_sample > w_peak_eff) ? r_sample : w_peak_eff;
                    end
                end
            end

            if (r_state == S_EVAL && !w_ramp_run) begin
                r_ramp_on <= 1'b0;
            end

            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd    <= i_cmd;
            r_sample <= i_sample_value;
        end
        if (r_state == S_EVAL) begin
            r_span <= GAIN_ONE - r_floor_gain;
            r_rem  <= '0;
            r_quot <= '0;
            r_cnt  <= '0;
            r_gain <= r_floor_gain;
        end
        if (r_state == S_DIV) begin
            r_span <= {r_span[GW-2:0], 1'b0};
            r_rem  <= n_rem;
            r_quot <= n_quot;
            r_cnt  <= r_cnt + 1'b1;
            if (w_div_last) begin
                r_gain <= GAIN_ONE - n_quot;
            end
        end
        if (w_load_out) begin
            r_out_gain  <= r_gain;
            r_out_ramp  <= r_ramp_on;
            r_out_fired <= r_fired;
            r_out_peak  <= r_peak_hold;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_gate_gain   = r_out_gain;
    assign o_ramp_active = r_out_ramp;
    assign o_fired       = r_out_fired;
    assign o_peak_level  = r_out_peak;

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < r_release_ms))
        else $error("division remainder out of range");

    a_div_ramp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> r_ramp_on)
        else $error("division running without an active ramp");

    a_gain_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && w_div_last) |=> (r_gain >= r_floor_gain))
        else $error("ramp gain below floor");

    a_fire_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EVAL && r_fired) |->
            (r_ramp_on && r_ramp_age == '0 && !r_scanning))
        else $error("fire did not restart ramp and close scan");

endmodule

// ===== tb/sv/drum_hit_peak_scan_gate_unit_test.sv =====
`timescale 1ns / 1ps

module drum_hit_peak_scan_gate_unit_test;
    import dhpsg_pkg::*;

    localparam int SAMPLE_BITS    = 12;
    localparam int GAIN_FRAC_BITS = 16;
    localparam longint unsigned UNITY = 64'd1 << GAIN_FRAC_BITS;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    localparam int IDLE_PCT       = 15;
    localparam int SETTLE_CYCLES  = 30;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASE_ITEMS    = 90;

    typedef struct packed {
        logic [GAIN_FRAC_BITS:0] gain;
        logic                    ramp;
        logic                    fired;
        logic [SAMPLE_BITS-1:0]  peak;
    } t_gate_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    logic i_cmd = 1'b0;
    logic [SAMPLE_BITS-1:0] i_sample_value = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    logic [GAIN_FRAC_BITS:0] o_gate_gain;
    logic o_ramp_active;
    logic o_fired;
    logic [SAMPLE_BITS-1:0] o_peak_level;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0] i_cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] i_cfg_wdata = '0;

    // configuration copy
    logic [THR_BITS-1:0]     thr_cfg     = RST_HIT_THRESHOLD;
    logic [LIMIT_BITS-1:0]   limit_cfg   = RST_SCAN_LIMIT;
    logic [RELEASE_BITS-1:0] release_cfg = RST_RELEASE;
    logic [RANGE_BITS-1:0]   range_cfg   = RST_RANGE;

    // gate state copy
    logic                    scan_open = 1'b0;
    int unsigned             scan_ms   = 0;
    logic [SAMPLE_BITS-1:0]  peak_now  = '0;
    logic                    ramp_run  = 1'b0;
    int unsigned             ramp_ms   = 0;
    longint unsigned         floor_now = 0;

    t_gate_result gate_expect_q[$];
    t_gate_result want;
    int errors = 0;
    int idle_cycles = 0;
    int phase_items = 0;
    logic calm = 1'b0;

    drum_hit_peak_scan_gate_unit #(
        .SAMPLE_BITS   (SAMPLE_BITS),
        .GAIN_FRAC_BITS(GAIN_FRAC_BITS)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_cmd         (i_cmd),
        .i_sample_value(i_sample_value),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_gate_gain   (o_gate_gain),
        .o_ramp_active (o_ramp_active),
        .o_fired       (o_fired),
        .o_peak_level  (o_peak_level),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always #4 i_clk = ~i_clk;

    // 2^(-r/6) in Q24
    function automatic longint unsigned atten_step_q24(input int unsigned r);
        case (r)
            0:       return 64'd16777216;
            1:       return 64'd14946800;
            2:       return 64'd13316085;
            3:       return 64'd11863283;
            4:       return 64'd10568984;
            default: return 64'd9415894;
        endcase
    endfunction

    function automatic longint unsigned floor_gain_of(input logic [RANGE_BITS-1:0] rng);
        int unsigned shift;
        longint unsigned base;
        shift = 24 - GAIN_FRAC_BITS + rng / 6;
        base  = atten_step_q24(rng % 6);
        if (shift == 0) begin
            return base;
        end
        if (shift >= 63) begin
            return 0;
        end
        return (base + (64'd1 << (shift - 1))) >> shift;
    endfunction

    task automatic predict_gate(input logic cmd, input logic [SAMPLE_BITS-1:0] smp);
        t_gate_result res;
        res = '0;
        if (cmd == CMD_TICK) begin
            if (scan_open && scan_ms < SCAN_AGE_MAX) scan_ms++;
            if (ramp_run && ramp_ms < RAMP_AGE_MAX) ramp_ms++;
        end else if (smp >= thr_cfg) begin
            if (!scan_open) begin
                scan_open = 1'b1;
                scan_ms   = 0;
                peak_now  = smp;
            end
            if (scan_ms > limit_cfg) begin
                // the firing sample leaves the peak alone
                scan_open = 1'b0;
                ramp_run  = 1'b1;
                ramp_ms   = 0;
                floor_now = floor_gain_of(range_cfg);
                res.fired = 1'b1;
            end else if (smp > peak_now) begin
                peak_now = smp;
            end
        end
        if (ramp_run && ramp_ms < release_cfg) begin
            res.gain = (GAIN_FRAC_BITS+1)'(UNITY - (longint'(ramp_ms) * (UNITY - floor_now))
                       / longint'(release_cfg));
        end else begin
            ramp_run = 1'b0;
            res.gain = (GAIN_FRAC_BITS+1)'(floor_now);
        end
        res.ramp = ramp_run;
        res.peak = peak_now;
        gate_expect_q.push_back(res);
    endtask

    task automatic send_item(input logic cmd, input logic [SAMPLE_BITS-1:0] smp);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_cmd          <= cmd;
        i_sample_value <= smp;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        predict_gate(cmd, smp);
        phase_items++;
    endtask

    task automatic tick();
        send_item(CMD_TICK, SAMPLE_BITS'($urandom));
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        while (gate_expect_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_word(input logic [CFG_IDX_BITS-1:0] idx,
                            input logic [CFG_DATA_BITS-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
    endtask

    // junk above the threshold, scan-limit and range widths must be dropped
    task automatic apply_settings(input logic [THR_BITS-1:0] thr,
                                  input logic [LIMIT_BITS-1:0] lim,
                                  input logic [RELEASE_BITS-1:0] rel,
                                  input logic [RANGE_BITS-1:0] rng);
        settle();
        cfg_word(CFG_HIT_THRESHOLD, {4'($urandom), thr});
        cfg_word(CFG_SCAN_LIMIT, {8'($urandom), lim});
        cfg_word(CFG_RELEASE, rel);
        cfg_word(CFG_RANGE, {9'($urandom), rng});
        i_cfg_we    <= 1'b0;
        thr_cfg     = thr;
        limit_cfg   = lim;
        release_cfg = rel;
        range_cfg   = rng;
    endtask

    function automatic logic [SAMPLE_BITS-1:0] hit_value();
        return SAMPLE_BITS'($urandom_range(thr_cfg, 4095));
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] quiet_value();
        if (thr_cfg == 0) begin
            return SAMPLE_BITS'($urandom);
        end
        return SAMPLE_BITS'($urandom_range(0, thr_cfg - 1));
    endfunction

    // defaults: gain stays zero until the first fire
    task automatic test_power_up();
        tick();
        send_item(CMD_SAMPLE, 12'd99);
        send_item(CMD_SAMPLE, 12'd0);
        send_item(CMD_SAMPLE, 12'd100);
        send_item(CMD_SAMPLE, 12'd4095);
        tick();
        send_item(CMD_SAMPLE, 12'd200);
    endtask

    task automatic test_fire_and_ramp();
        apply_settings(12'd100, 8'd0, 16'd3, 7'd127);
        send_item(CMD_SAMPLE, 12'd500);
        tick();
        send_item(CMD_SAMPLE, 12'd99);
        send_item(CMD_SAMPLE, 12'd900);
        tick();
        send_item(CMD_SAMPLE, 12'd600);
        tick();
        // fires again while the ramp runs, so the ramp restarts
        send_item(CMD_SAMPLE, 12'd650);
        repeat (4) tick();
    endtask

    task automatic test_zero_release_and_range_ends();
        apply_settings(12'd0, 8'd0, 16'd0, 7'd96);
        send_item(CMD_SAMPLE, 12'd0);
        tick();
        send_item(CMD_SAMPLE, 12'd4095);
        tick();
        apply_settings(12'd4095, 8'd0, 16'd2, 7'd0);
        send_item(CMD_SAMPLE, 12'd4095);
        tick();
        send_item(CMD_SAMPLE, 12'd4095);
        tick();
    endtask

    // scan age has to stick at its top instead of wrapping back below the limit
    task automatic test_scan_age_saturation();
        apply_settings(12'd4095, 8'd255, 16'd65535, 7'd1);
        send_item(CMD_SAMPLE, 12'd4095);
        repeat (520) tick();
        send_item(CMD_SAMPLE, 12'd4095);
        repeat (3) tick();
    endtask

    task automatic hit_sequence();
        int unsigned aged;
        int unsigned tail;
        int unsigned pick;
        aged = 0;
        repeat ($urandom_range(0, 2)) send_item(CMD_SAMPLE, quiet_value());
        send_item(CMD_SAMPLE, hit_value());
        while (aged <= limit_cfg) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                tick();
                aged++;
            end else if (pick < 85) begin
                send_item(CMD_SAMPLE, hit_value());
            end else begin
                send_item(CMD_SAMPLE, quiet_value());
            end
        end
        // some scans are left open and run into the next sequence
        if ($urandom_range(0, 9) != 0) begin
            send_item(CMD_SAMPLE, hit_value());
        end
        tail = (release_cfg < 48) ? release_cfg + 2 : 48;
        repeat ($urandom_range(0, tail)) tick();
    endtask

    task automatic run_phase(input logic [THR_BITS-1:0] thr,
                             input logic [LIMIT_BITS-1:0] lim,
                             input logic [RELEASE_BITS-1:0] rel,
                             input logic [RANGE_BITS-1:0] rng);
        apply_settings(thr, lim, rel, rng);
        phase_items = 0;
        while (phase_items < PHASE_ITEMS) begin
            if ($urandom_range(0, 4) != 0) begin
                hit_sequence();
            end else begin
                repeat ($urandom_range(1, 6))
                    send_item(1'($urandom), SAMPLE_BITS'($urandom));
            end
        end
    endtask

    task automatic test_random_hits();
        run_phase(12'd0, 8'd0, 16'd1, 7'd0);
        run_phase(12'd4095, 8'd3, 16'd65535, 7'd96);
        calm = 1'b1;
        run_phase(12'd2048, 8'd5, 16'd17, 7'd127);
        calm = 1'b0;
        run_phase(12'($urandom), 8'($urandom_range(0, 10)), 16'd0, 7'($urandom));
        repeat (4) begin
            run_phase(12'($urandom), 8'($urandom_range(0, 10)),
                      16'($urandom_range(1, 40)), 7'($urandom));
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (gate_expect_q.size() == 0) begin
                $error("result transaction with nothing expected");
                errors++;
            end else begin
                want = gate_expect_q.pop_front();
                if (o_gate_gain !== want.gain) begin
                    $error("gate_gain expected %0d actual %0d", want.gain, o_gate_gain);
                    errors++;
                end
                if (o_ramp_active !== want.ramp) begin
                    $error("ramp_active expected %0d actual %0d", want.ramp, o_ramp_active);
                    errors++;
                end
                if (o_fired !== want.fired) begin
                    $error("fired expected %0d actual %0d", want.fired, o_fired);
                    errors++;
                end
                if (o_peak_level !== want.peak) begin
                    $error("peak_level expected %0d actual %0d", want.peak, o_peak_level);
                    errors++;
                end
            end
        end
        i_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == WATCHDOG_LIMIT) begin
                $display("drum_hit_peak_scan_gate_unit verification failed");
                $finish;
            end
        end
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_power_up();
        test_fire_and_ramp();
        test_zero_release_and_range_ends();
        test_scan_age_saturation();
        test_random_hits();
        settle();
        if (errors == 0 && gate_expect_q.size() == 0) begin
            $display("drum_hit_peak_scan_gate_unit verification clean");
        end else begin
            $display("drum_hit_peak_scan_gate_unit verification failed");
        end
        $finish;
    end

endmodule
